>>> rtl/core/amas_pkg.sv
// Package for the motor auto-arm supervisor: register indexes, axis state
// codes, reset values and the structs passed between the supervisor modules.
// No dependencies.
package amas_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int ATT_W      = 9;
	localparam int CAL_W      = 16;
	localparam int ARMED_W    = 17;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CAL_TIMEOUT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ARMED_HOLD  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_GAP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_GAP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_LIMIT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ATT     = 3'd5;

	// register reset values
	localparam logic [15:0]      RST_CAL_TIMEOUT = 16'd12000;
	localparam logic [15:0]      RST_ARMED_HOLD  = 16'd1000;
	localparam logic [15:0]      RST_FAST_GAP    = 16'd50;
	localparam logic [15:0]      RST_SLOW_GAP    = 16'd250;
	localparam logic [ATT_W-1:0] RST_FAST_LIMIT  = 9'd10;
	localparam logic [ATT_W-1:0] RST_MAX_ATT     = 9'd300;

	// drive axis state codes
	localparam logic [3:0] AXIS_IDLE        = 4'd1;
	localparam logic [3:0] AXIS_CAL_MOTOR   = 4'd3;
	localparam logic [3:0] AXIS_CAL_ENC_IDX = 4'd4;
	localparam logic [3:0] AXIS_CAL_ENC_OFS = 4'd6;
	localparam logic [3:0] AXIS_CAL_ENC_DIR = 4'd7;
	localparam logic [3:0] AXIS_CLOSED_LOOP = 4'd8;

	localparam logic [CAL_W-1:0] CAL_SAT = '1;

	typedef struct packed {
		logic [15:0]      cal_timeout;
		logic [15:0]      armed_hold;
		logic [15:0]      fast_gap;
		logic [15:0]      slow_gap;
		logic [ATT_W-1:0] fast_limit;
		logic [ATT_W-1:0] max_att;
	} cfg_t;

	typedef struct packed {
		logic [3:0] axis_state;
		logic       motor_armed;
		logic       save_pending;
	} tick_in_t;

	typedef struct packed {
		logic             request_idle;
		logic             commit_save;
		logic             arm_request;
		logic [ATT_W-1:0] attempt_count;
		logic             gate_open;
	} tick_res_t;

endpackage

>>> rtl/core/amas_cfg.sv
// Configuration register file of the auto-arm supervisor.
// Depends on amas_pkg.
module amas_cfg
	import amas_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cal_timeout <= RST_CAL_TIMEOUT;
			cfg_q.armed_hold  <= RST_ARMED_HOLD;
			cfg_q.fast_gap    <= RST_FAST_GAP;
			cfg_q.slow_gap    <= RST_SLOW_GAP;
			cfg_q.fast_limit  <= RST_FAST_LIMIT;
			cfg_q.max_att     <= RST_MAX_ATT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CAL_TIMEOUT: cfg_q.cal_timeout <= cfg_wdata;
				REG_ARMED_HOLD:  cfg_q.armed_hold  <= cfg_wdata;
				REG_FAST_GAP:    cfg_q.fast_gap    <= cfg_wdata;
				REG_SLOW_GAP:    cfg_q.slow_gap    <= cfg_wdata;
				REG_FAST_LIMIT:  cfg_q.fast_limit  <= cfg_wdata[ATT_W-1:0];
				REG_MAX_ATT:     cfg_q.max_att     <= cfg_wdata[ATT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/core/amas_step.sv
// Supervisor state registers and the per-tick update logic.
// Depends on amas_pkg.
module amas_step
	import amas_pkg::*;
#(
	parameter int TICK_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      advance,
	input  tick_in_t  item,
	input  cfg_t      cfg,
	output tick_res_t res
);

	logic [TICK_BITS-1:0] tick_q, next_try_q;
	logic [CAL_W-1:0]     cal_q;
	logic [ARMED_W-1:0]   armed_q;
	logic [ATT_W-1:0]     att_q;
	logic                 gate_q;

	logic [TICK_BITS-1:0] next_try_d, diff;
	logic [CAL_W-1:0]     cal_d;
	logic [ARMED_W-1:0]   armed_d;
	logic [ATT_W-1:0]     att_d;
	logic                 gate_d, in_cal, req_idle, commit, arm_req;

	always_comb begin
		next_try_d = next_try_q;
		cal_d      = cal_q;
		armed_d    = armed_q;
		att_d      = att_q;
		gate_d     = gate_q;
		req_idle   = 1'b0;
		commit     = 1'b0;
		arm_req    = 1'b0;
		diff       = tick_q - next_try_q;
		in_cal     = (item.axis_state == AXIS_CAL_MOTOR)   ||
		             (item.axis_state == AXIS_CAL_ENC_IDX) ||
		             (item.axis_state == AXIS_CAL_ENC_OFS) ||
		             (item.axis_state == AXIS_CAL_ENC_DIR);

		// pending save: hold the gate shut until the motor is disarmed
		if (item.save_pending) begin
			if (item.motor_armed) begin
				gate_d   = 1'b0;
				req_idle = 1'b1;
			end else begin
				commit = 1'b1;
				gate_d = 1'b1;
			end
		end

		if (in_cal) begin
			if (cal_q >= cfg.cal_timeout)
				req_idle = 1'b1;
			if (cal_q != CAL_SAT)
				cal_d = cal_q + 1'b1;
		end else begin
			cal_d = '0;
			if (item.axis_state == AXIS_CLOSED_LOOP) begin
				if (armed_q <= {1'b0, cfg.armed_hold}) begin
					armed_d = armed_q + 1'b1;
					if (armed_q == {1'b0, cfg.armed_hold})
						att_d = '0;
				end
			end else if (item.axis_state == AXIS_IDLE && gate_d) begin
				armed_d = '0;
				if (!diff[TICK_BITS-1] && att_q < cfg.max_att) begin
					arm_req = 1'b1;
					att_d   = att_q + 1'b1;
					next_try_d = tick_q + TICK_BITS'((att_d < cfg.fast_limit) ?
						cfg.fast_gap : cfg.slow_gap);
				end
			end
		end

		res.request_idle  = req_idle;
		res.commit_save   = commit;
		res.arm_request   = arm_req;
		res.attempt_count = att_d;
		res.gate_open     = gate_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q     <= '0;
			next_try_q <= '0;
			cal_q      <= '0;
			armed_q    <= '0;
			att_q      <= '0;
			gate_q     <= 1'b1;
		end else if (advance) begin
			tick_q     <= tick_q + 1'b1;
			next_try_q <= next_try_d;
			cal_q      <= cal_d;
			armed_q    <= armed_d;
			att_q      <= att_d;
			gate_q     <= gate_d;
		end
	end

endmodule

>>> rtl/core/motor_auto_arm_supervisor.sv
// Motor auto-arm supervisor, top level: input register, update logic and
// output register. Depends on amas_pkg, amas_cfg and amas_step.
// Path: input register, then result register, then out on m_axis.
// Throughput: one request per cycle; the output register frees the input
// register whenever the result is taken or the output slot is empty.
// Reset clears valid and step state, loads register defaults, opens the gate.
module motor_auto_arm_supervisor
	import amas_pkg::*;
#(
	parameter int TICK_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// tick requests in
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [3:0] axis_state, [4] motor_armed, [5] save_pending, [7:6] zero
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// results out
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [0] request_idle, [1] commit_save, [2] arm_request,
	// [11:3] attempt_count, [12] gate_open, [15:13] zero
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	cfg_t      cfg;
	tick_in_t  item_s1;
	logic      valid_s1;
	tick_res_t res, res_s2;
	logic      valid_s2;
	logic      advance;

	// the input stage moves on when the output slot is empty or being drained
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	amas_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	amas_step #(
		.TICK_BITS (TICK_BITS)
	) u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.axis_state   <= s_axis_tdata[3:0];
			item_s1.motor_armed  <= s_axis_tdata[4];
			item_s1.save_pending <= s_axis_tdata[5];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res;
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {3'b000, res_s2.gate_open, res_s2.attempt_count,
		res_s2.arm_request, res_s2.commit_save, res_s2.request_idle};

endmodule

>>> rtl/core/amas_checker.sv
// Port-level checks for the auto-arm supervisor, bound to the top level.
// Depends on amas_pkg and motor_auto_arm_supervisor.
module amas_checker
	import amas_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// a committed save always reopens the gate in the same tick
	a_commit_gate: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[12])
		else $error("commit_save with gate closed");

	// arm requests only go out through an open gate
	a_arm_gate: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[12])
		else $error("arm_request with gate closed");

	// an arm request always leaves a nonzero attempt count
	a_arm_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[11:3] != '0)
		else $error("arm_request with zero attempt count");

endmodule

bind motor_auto_arm_supervisor amas_checker u_amas_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
